// ===== hdl/lrucl_pkg.sv =====
// lrucl_pkg: shared constants and types for the lru cache lookup/fill block
// no dependencies; imported by every other file of the block
package lrucl_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int VALUE_BITS_DEF = 64;

  localparam int KEY_W      = 32;
  localparam int SLOT_W     = 4;
  localparam int HITS_W     = 32;
  localparam int CAP_REG_W  = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

  // outcome of one lookup, passed from the tag array to the top level
  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } lookup_t;

endpackage

// ===== hdl/lrucl_if.sv =====
// lrucl_req_if / lrucl_rsp_if: valid/ready channels of the lru cache block
// depends on lrucl_pkg for field widths
interface lrucl_req_if
  import lrucl_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [KEY_W-1:0]      key;
  logic [VALUE_BITS-1:0] fill_value;

  modport source (output valid, key, fill_value, input ready);
  modport sink   (input valid, key, fill_value, output ready);
endinterface

interface lrucl_rsp_if
  import lrucl_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] value;
  logic [SLOT_W-1:0]     slot;
  logic [HITS_W-1:0]     hits_so_far;

  modport source (output valid, hit, value, slot, hits_so_far, input ready);
  modport sink   (input valid, hit, value, slot, hits_so_far, output ready);
endinterface

// ===== hdl/lru_cache_lookup_fill.sv =====
// lru_cache_lookup_fill: fully associative cache with lru replacement, top level
// depends on lrucl_pkg, lrucl_if, lrucl_cfg_regs, lrucl_tag_array, lrucl_value_ram
//
//   port      dir   handshake                    carries
//   in_item   sink  valid/ready                  key, fill_value
//   out_item  src   valid/ready                  hit, value, slot, hits_so_far
//   cfg_*     slave apb, pready tied high        capacity at byte address 0
//
// one item per cycle sustained while out_item.ready is high: input register, then
// lookup and update into the result register, where a result waits until it is taken;
// the path between the registers is the parallel key compare plus the age update;
// tag and age state change at the same edge, so the next item sees them at once
// reset (rst_n, synchronous) empties the cache, clears the hit count, capacity = entries
// a stalled result holds both registers; in_item.ready drops only when both are full
module lru_cache_lookup_fill
  import lrucl_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lrucl_req_if.sink             in_item,
  lrucl_rsp_if.source           out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // input register
  logic                  in_v_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] fill_r;

  // result register
  logic                  out_v_r;
  logic                  hit_o_r;
  logic [VALUE_BITS-1:0] fill_o_r;
  logic [SLOT_W-1:0]     slot_o_r;
  logic [HITS_W-1:0]     hits_o_r;

  // saturating hit counter
  logic [HITS_W-1:0] hit_total_r;
  logic [HITS_W-1:0] hit_total_nxt;

  logic [CNT_W-1:0]      eff_cap;
  lookup_t               lk;
  logic [IDX_W-1:0]      slot;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  advance;
  logic                  take_in;

  // the lookup moves on whenever the result register is free or being drained
  assign advance         = in_v_r && (!out_v_r || out_item.ready);
  assign in_item.ready   = !in_v_r || advance;
  assign take_in         = in_item.valid && in_item.ready;

  lrucl_cfg_regs #(
    .ENTRIES (ENTRIES)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .eff_cap (eff_cap)
  );

  lrucl_tag_array #(
    .ENTRIES (ENTRIES)
  ) u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .key     (key_r),
    .eff_cap (eff_cap),
    .upd_en  (advance),
    .lk      (lk),
    .slot    (slot)
  );

  // a miss writes the fill value; a hit reads the stored one into its
  // output register, which sits alongside the result register
  lrucl_value_ram #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_values (
    .clk   (clk),
    .we    (advance && !lk.hit),
    .waddr (slot),
    .wdata (fill_r),
    .re    (advance),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    hit_total_nxt = hit_total_r;
    if (lk.hit && (hit_total_r != '1)) begin
      hit_total_nxt = hit_total_r + HITS_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      hit_total_r <= '0;
    end else begin
      if (in_item.ready) begin
        in_v_r <= in_item.valid;
      end
      if (advance) begin
        out_v_r     <= 1'b1;
        hit_total_r <= hit_total_nxt;
      end else if (out_item.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      key_r  <= in_item.key;
      fill_r <= in_item.fill_value;
    end
    if (advance) begin
      hit_o_r  <= lk.hit;
      fill_o_r <= fill_r;
      slot_o_r <= SLOT_W'(XW'(slot));
      hits_o_r <= hit_total_nxt;
    end
  end

  assign out_item.valid       = out_v_r;
  assign out_item.hit         = hit_o_r;
  assign out_item.value       = hit_o_r ? ram_rdata : fill_o_r;
  assign out_item.slot        = slot_o_r;
  assign out_item.hits_so_far = hits_o_r;

endmodule

// ===== hdl/lrucl_cfg_regs.sv =====
// lrucl_cfg_regs: apb capacity register and effective capacity clamp
// depends on lrucl_pkg
module lrucl_cfg_regs
  import lrucl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int CNT_W  = $clog2(ENTRIES + 1),
  localparam int CAP_W  = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CNT_W-1:0]      eff_cap
);

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && (paddr == ADDR_CAPACITY)) begin
      cap_nxt = CAP_W'(pwdata[CAP_REG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(ENTRIES);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // zero acts as one, anything above the built size acts as the built size
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_r > CAP_W'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? CFG_DATA_W'(cap_r) : '0;

endmodule

// ===== hdl/lrucl_tag_array.sv =====
// lrucl_tag_array: key store, recency ages and fill count with parallel lookup
// depends on lrucl_pkg
module lrucl_tag_array
  import lrucl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] eff_cap,
  input  logic             upd_en,
  output lookup_t          lk,
  output logic [IDX_W-1:0] slot
);

  logic [KEY_W-1:0] key_r [ENTRIES];
  logic [IDX_W-1:0] age_r [ENTRIES];
  logic [IDX_W-1:0] age_nxt [ENTRIES];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic [ENTRIES-1:0] filled;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   old_idx;
  logic [IDX_W-1:0]   hit_age;
  logic               room;

  // keys stored are distinct and ages are a permutation, so at most one
  // match and exactly one oldest entry: or-combining the indexes is enough
  always_comb begin
    hit_idx = '0;
    old_idx = '0;
    hit_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      filled[i] = CNT_W'(i) < cnt_r;
      match[i]  = filled[i] && (key_r[i] == key);
      oldest[i] = filled[i] && ((CNT_W'(age_r[i]) + CNT_W'(1)) == cnt_r);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_age = hit_age | age_r[i];
      end
      if (oldest[i]) begin
        old_idx = old_idx | IDX_W'(i);
      end
    end
  end

  assign room     = cnt_r < eff_cap;
  assign lk.hit   = |match;
  assign lk.fill  = !lk.hit && room;
  assign lk.evict = !lk.hit && !room;

  always_comb begin
    if (lk.hit) begin
      slot = hit_idx;
    end else if (room) begin
      slot = cnt_r[IDX_W-1:0];
    end else begin
      slot = old_idx;
    end
  end

  // touched entry goes to age zero; younger ones (all on a miss) age by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      if (IDX_W'(i) == slot) begin
        age_nxt[i] = '0;
      end else if (filled[i] && (!lk.hit || (age_r[i] < hit_age))) begin
        age_nxt[i] = age_r[i] + IDX_W'(1);
      end
    end
    cnt_nxt = lk.fill ? cnt_r + CNT_W'(1) : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (upd_en) begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && !lk.hit) begin
      key_r[slot] <= key;
    end
  end

endmodule

// ===== hdl/lrucl_value_ram.sv =====
// lrucl_value_ram: per-slot value store with registered read
// depends on lrucl_pkg
module lrucl_value_ram
  import lrucl_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [ENTRIES];
  logic [VALUE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/lrucl_checker.sv =====
`timescale 1ns / 100ps
// lrucl_checker: watches the request, result and register ports of the lru cache,
// predicts every result and compares it field by field
// depends on lrucl_pkg and the lrucl_req_if / lrucl_rsp_if interfaces
module lrucl_checker
  import lrucl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lrucl_req_if                  req_mon,
  lrucl_rsp_if                  rsp_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatches,
  output int                    pending,
  output int                    results_seen,
  output int                    hits_seen,
  output int                    evictions
);

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int VB      = VALUE_BITS_DEF;

  typedef struct packed {
    logic              hit;
    logic [VB-1:0]     value;
    logic [SLOT_W-1:0] slot;
    logic [HITS_W-1:0] hits_so_far;
  } cache_rsp_t;

  // shadow copy of the cache
  logic [KEY_W-1:0]     tags [ENTRIES];
  logic [VB-1:0]        vals [ENTRIES];
  logic [SLOT_W-1:0]    ages [ENTRIES];
  logic [CAP_REG_W-1:0] filled;
  logic [HITS_W-1:0]    hit_count;
  logic [CAP_REG_W-1:0] capacity;

  cache_rsp_t expected_rsps[$];

  // make slot s most recent, aging every filled slot younger than limit
  function automatic void promote(int s, int limit);
    for (int i = 0; i < int'(filled); i++)
      if (i != s && int'(ages[i]) < limit) ages[i] = ages[i] + 1'b1;
    ages[s] = '0;
  endfunction

  function automatic cache_rsp_t lookup_and_update(logic [KEY_W-1:0] key,
                                                   logic [VB-1:0] fill);
    cache_rsp_t r;
    int found_at;
    int cap_eff;
    int victim;
    int oldest;
    found_at = -1;
    cap_eff = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
    for (int i = 0; i < int'(filled); i++)
      if (found_at < 0 && tags[i] == key) found_at = i;
    if (found_at >= 0) begin
      if (hit_count != '1) hit_count = hit_count + 1'b1;
      promote(found_at, int'(ages[found_at]));
      r.hit = 1'b1;
      r.value = vals[found_at];
      r.slot = SLOT_W'(found_at);
    end else if (int'(filled) < cap_eff) begin
      victim = int'(filled);
      filled = filled + 1'b1;
      tags[victim] = key;
      vals[victim] = fill;
      promote(victim, 256);
      r.hit = 1'b0;
      r.value = fill;
      r.slot = SLOT_W'(victim);
    end else begin
      // full, or capacity lowered below the fill level: reuse the least recent slot
      victim = 0;
      oldest = 0;
      for (int i = 0; i < int'(filled); i++)
        if (int'(ages[i]) >= oldest) begin
          oldest = int'(ages[i]);
          victim = i;
        end
      tags[victim] = key;
      vals[victim] = fill;
      promote(victim, 256);
      evictions++;
      r.hit = 1'b0;
      r.value = fill;
      r.slot = SLOT_W'(victim);
    end
    r.hits_so_far = hit_count;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    cache_rsp_t want;
    cache_rsp_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) ages[i] = '0;
      filled = '0;
      hit_count = '0;
      capacity = CAP_REG_W'(ENTRIES);
      expected_rsps.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_CAPACITY)
        capacity = cfg_pwdata[CAP_REG_W-1:0];
      if (req_mon.valid && req_mon.ready)
        expected_rsps.push_back(lookup_and_update(req_mon.key, req_mon.fill_value));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.hit = rsp_mon.hit;
        got.value = rsp_mon.value;
        got.slot = rsp_mon.slot;
        got.hits_so_far = rsp_mon.hits_so_far;
        results_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: hit=%0b value=%h slot=%0d hits=%0d",
                     $time, got.hit, got.value, got.slot, got.hits_so_far);
        end else begin
          want = expected_rsps.pop_front();
          if (want.hit) hits_seen++;
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected hit=%0b value=%h slot=%0d hits=%0d,",
                       $time, want.hit, want.value, want.slot, want.hits_so_far);
              $display("    got hit=%0b value=%h slot=%0d hits=%0d",
                       got.hit, got.value, got.slot, got.hits_so_far);
            end
          end
        end
      end
    end
    pending = expected_rsps.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: stimulus, register writes and verdict for lru_cache_lookup_fill
// depends on lrucl_pkg, lrucl_if, the block itself and lrucl_checker
module testbench;
  import lrucl_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int IDLE_LIMIT  = 500;   // cycles with no handshake before giving up
  localparam int LONG_HOLD   = 48;    // receiver hold-off, long enough to back up the input

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lrucl_req_if #(.VALUE_BITS(VALUE_BITS_DEF)) req_if ();
  lrucl_rsp_if #(.VALUE_BITS(VALUE_BITS_DEF)) rsp_if ();

  int mismatches;
  int pending;
  int results_seen;
  int hits_seen;
  int evictions;

  // random idling switches, flipped per phase by the main sequence
  bit tx_gaps;
  bit rx_gaps;
  int hold_reqs;     // long hold-offs asked for by the main sequence
  int cap_writes;
  int idle_cycles;

  lru_cache_lookup_fill u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (req_if),
    .out_item   (rsp_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  lrucl_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen),
    .hits_seen   (hits_seen),
    .evictions   (evictions)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: random stall bursts, plus one long hold-off on request,
  // counted here so the sender keeps pushing while the result path is blocked
  initial begin
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        stall_left = LONG_HOLD;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      rsp_if.ready <= (stall_left == 0) && rst_n;
    end
  end

  // watchdog: any cycle without a handshake on any port counts toward the limit
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item and return at the edge that takes it; called and returns on a
  // rising edge, so valid stays high across back-to-back items
  task automatic send_request(input logic [KEY_W-1:0] key,
                              input logic [VALUE_BITS_DEF-1:0] fill);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.key <= key;
    req_if.fill_value <= fill;
    // ready is settled by the falling edge, so the next rising edge takes the item
    do @(negedge clk); while (!req_if.ready);
    @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result, plus the pipeline depth
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the capacity register; upper data bits carry junk on purpose
  task automatic write_capacity(input logic [CAP_REG_W-1:0] cap);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CAPACITY;
    cfg_pwdata <= {(CFG_DATA_W - CAP_REG_W)'($urandom), cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [VALUE_BITS_DEF-1:0] pick_fill();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [KEY_W-1:0] key_pool [32];
    int pool_size;
    int phase_caps [NUM_PHASES];
    logic [KEY_W-1:0] key;

    phase_caps = '{16, 1, 0, 31, 8, 3, 0, 16};
    phase_caps[6] = $urandom_range(2, 15);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    cap_writes = 0;

    // every input known from time zero
    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.key <= '0;
    req_if.fill_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and alternating bit patterns, with hits on all keys but 32'h5555_5555
    send_request('0, '0);
    send_request('1, '1);
    send_request('0, 64'h0123_4567_89ab_cdef);          // hit, stored zero comes back
    send_request('1, '0);                               // hit, all ones come back
    send_request(32'haaaa_aaaa, 64'h5555_5555_5555_5555);
    send_request(32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(32'haaaa_aaaa, '0);                    // hit
    drain_results();

    // capacity one while four slots are filled: the cache counts as full,
    // so misses replace the least recent of all filled slots
    write_capacity(5'd1);
    send_request(32'h0000_0001, 64'h11);
    send_request(32'h0000_0001, 64'h22);                // hit
    send_request(32'h0000_0002, 64'h33);
    drain_results();

    // capacity zero acts as one
    write_capacity(5'd0);
    send_request(32'h0000_0003, 64'h44);
    send_request(32'h0000_0004, 64'h55);
    drain_results();

    // above the entry count saturates: fill the remaining slots, then evict twice
    write_capacity(5'd31);
    for (int i = 0; i < 14; i++)
      send_request(32'h100 + i, {$urandom, $urandom});
    drain_results();

    // random phases: keys drawn mostly from a small pool so that hits, fills and
    // evictions all happen, with a fresh capacity each phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(CAP_REG_W'(phase_caps[p]));
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < pool_size; i++)
        key_pool[i] = $urandom;
      // idling on some phases only; the last phase runs flat out
      tx_gaps = (p != NUM_PHASES - 1) && (p % 3 != 2);
      rx_gaps = (p != NUM_PHASES - 1) && (p % 3 != 0 || p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 1 || p == 4) && n == 60)
          hold_reqs++;
        if ($urandom_range(0, 7) == 0)
          key = $urandom;
        else
          key = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(key, pick_fill());
      end
      drain_results();
    end

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (8) @(posedge clk);

    $display("run covered %0d results (%0d hits, %0d evictions) over %0d capacity writes",
             results_seen, hits_seen, evictions, cap_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lrucl_pkg.sv
hdl/lrucl_if.sv
hdl/lrucl_cfg_regs.sv
hdl/lrucl_tag_array.sv
hdl/lrucl_value_ram.sv
hdl/lru_cache_lookup_fill.sv
tb/lrucl_checker.sv
tb/testbench.sv
